/* rtl/lbbs_pkg.sv */
// Shared types and constants for the longest balanced bracket span block.
package lbbs_pkg;

  localparam int TOKEN_WIDTH = 16;
  localparam int LENGTH_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [TOKEN_WIDTH-1:0] bracket_value;
    logic                          last_item;
  } tok_t;

  typedef struct packed {
    logic [LENGTH_WIDTH-1:0] longest_length;
    logic                    overflow;
  } res_t;

  // Classified token: kind is the type opened, or the type a close wants.
  typedef struct packed {
    logic                   is_open;
    logic [TOKEN_WIDTH-1:0] kind;
    logic                   last;
  } op_t;

endpackage

/* rtl/longest_balanced_bracket_span.sv */
// Longest balanced bracket span: one token per cycle when not stalled, result on each last token.
// res_valid is registered and rises as the back end takes the last token from the queue.
// Throughput: one token per cycle; a waiting result stalls the next last token and, once full, the queue behind it.
// The stack lives in one RAM; the top two entries are held in registers and the third is prefetched.
// Reset (synchronous) clears the queue, counters and flags; stack RAM contents are not cleared.
// After each last token the span counters and flags return to their reset values by themselves.
module longest_balanced_bracket_span #(
  parameter int STACK_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_valid,
  output logic           tok_ready,
  input  lbbs_pkg::tok_t  tok,
  output logic           res_valid,
  input  logic           res_ready,
  output lbbs_pkg::res_t  res
);
  import lbbs_pkg::*;

  logic op_valid;
  logic op_take;
  op_t  op;

  lbbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op)
  );

  lbbs_back #(
    .STACK_DEPTH    (STACK_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

/* rtl/lbbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lbbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lbbs_front.sv */
// Front end: accepts tokens, classifies them and queues them for the back end.
module lbbs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  output logic          tok_ready,
  input  lbbs_pkg::tok_t tok,
  output logic          op_valid,
  input  logic          op_take,
  output lbbs_pkg::op_t  op
);
  import lbbs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  op_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  op_t          cls;
  logic         push;
  logic         pop;

  // Negative opens nothing: it closes the type equal to its negation.
  always_comb begin
    cls.is_open = !tok.bracket_value[TOKEN_WIDTH-1];
    cls.kind    = cls.is_open ? tok.bracket_value : (~tok.bracket_value + 1'b1);
    cls.last    = tok.last_item;
  end

  assign tok_ready = (fill != FW'(QUEUE_DEPTH));
  assign op_valid  = (fill != '0);
  assign op        = slots[rd_ptr];
  assign push      = tok_valid && tok_ready;
  assign pop       = op_valid && op_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/lbbs_back.sv */
// Back end: stack execution with cached top entries, span tracking and result register.
module lbbs_back #(
  parameter int STACK_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_take,
  input  lbbs_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_ready,
  output lbbs_pkg::res_t res
);
  import lbbs_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int BW = POSITION_WIDTH + 1;
  localparam int EW = TOKEN_WIDTH + POSITION_WIDTH;
  localparam logic [LENGTH_WIDTH-1:0] MAX_LEN = '1;

  logic [CW-1:0]             count, count_next;
  logic [BW-1:0]             base, base_next;
  logic [POSITION_WIDTH-1:0] pos, pos_next;
  logic [LENGTH_WIDTH-1:0]   best, best_next;
  logic                      ovf, ovf_next;
  logic [TOKEN_WIDTH-1:0]    top_kind, top_kind_next, sec_kind, sec_kind_next;
  logic [POSITION_WIDTH-1:0] top_pos, top_pos_next, sec_pos, sec_pos_next;

  logic                      go;
  logic                      pos_full;
  logic                      do_push;
  logic [BW-1:0]             span_from;
  logic [BW-1:0]             span_len;
  logic [LENGTH_WIDTH-1:0]   span_sat;
  logic [CW-1:0]             rd_index;
  logic [EW-1:0]             ram_rdata;

  assign op_take  = go;
  assign go       = op_valid && (!op.last || !res_valid || res_ready);
  assign pos_full = (pos == '1);

  // Span back to the entry below the popped one, or to the base if none is left.
  assign span_from = (count == CW'(1)) ? base : {1'b0, sec_pos};
  assign span_len  = {1'b0, pos} - span_from;
  assign span_sat  = (span_len > BW'(MAX_LEN)) ? MAX_LEN : LENGTH_WIDTH'(span_len);

  always_comb begin
    count_next    = count;
    base_next     = base;
    pos_next      = pos;
    best_next     = best;
    ovf_next      = ovf;
    top_kind_next = top_kind;
    top_pos_next  = top_pos;
    sec_kind_next = sec_kind;
    sec_pos_next  = sec_pos;
    do_push       = 1'b0;
    if (go) begin
      if (pos_full) begin
        ovf_next   = 1'b1;
        count_next = '0;
        base_next  = {1'b0, pos};
      end else begin
        pos_next = pos + 1'b1;
        if (op.is_open) begin
          if (count == CW'(STACK_DEPTH)) begin
            ovf_next   = 1'b1;
            count_next = '0;
            base_next  = {1'b0, pos};
          end else begin
            do_push       = 1'b1;
            count_next    = count + 1'b1;
            top_kind_next = op.kind;
            top_pos_next  = pos;
            sec_kind_next = top_kind;
            sec_pos_next  = top_pos;
          end
        end else if (count != '0 && top_kind == op.kind) begin
          count_next    = count - 1'b1;
          top_kind_next = sec_kind;
          top_pos_next  = sec_pos;
          sec_kind_next = ram_rdata[EW-1:POSITION_WIDTH];
          sec_pos_next  = ram_rdata[POSITION_WIDTH-1:0];
          if (span_sat > best) begin
            best_next = span_sat;
          end
        end else begin
          count_next = '0;
          base_next  = {1'b0, pos};
        end
      end
    end
  end

  // Prefetch the third entry from the top so a pop can refill the second slot.
  assign rd_index = count_next - CW'(3);

  lbbs_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (do_push),
    .waddr (count[AW-1:0]),
    .wdata ({op.kind, pos}),
    .raddr (rd_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    top_kind <= top_kind_next;
    top_pos  <= top_pos_next;
    sec_kind <= sec_kind_next;
    sec_pos  <= sec_pos_next;
    if (go && op.last) begin
      res.longest_length <= best_next;
      res.overflow       <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      base      <= '1;
      pos       <= '0;
      best      <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (go && op.last) begin
        // Emit and start the next sequence from a clean state.
        res_valid <= 1'b1;
        count     <= '0;
        base      <= '1;
        pos       <= '0;
        best      <= '0;
        ovf       <= 1'b0;
      end else begin
        if (res_ready) begin
          res_valid <= 1'b0;
        end
        count <= count_next;
        base  <= base_next;
        pos   <= pos_next;
        best  <= best_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the longest balanced bracket span block.
module tb_top;
  import lbbs_pkg::*;

  localparam int STACK_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 470;
  localparam int CALM_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_AFTER  = 15;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [15:0] POS_LAST = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] val;
    logic               fin;
    logic               known;
    logic [15:0]        len;
    logic               ovf;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tok_valid = 1'b0;
  logic tok_ready;
  tok_t tok_req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Typed-in expectation that travels with the current request.
  logic req_known = 1'b0;
  res_t req_want = '0;

  // Predictor state.
  int          open_kind [STACK_DEPTH];
  logic [15:0] open_at [STACK_DEPTH];
  int          depth_now;
  logic [16:0] wall_pos;
  logic [15:0] pos_now;
  logic [15:0] best_span;
  logic        ovf_seen;

  res_t due [$];
  res_t predicted;
  res_t want_now;
  int   errors = 0;
  int   tokens_in = 0;
  int   res_seen = 0;
  int   seq_sent = 0;
  int   ovf_results = 0;
  int   idle_cycles = 0;
  bit   tx_idle_on = 1'b0;
  bit   calm = 1'b0;

  row_t plan [23];

  longest_balanced_bracket_span u_top (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void span_clear();
    depth_now = 0;
    wall_pos  = '1;
    pos_now   = '0;
    best_span = '0;
    ovf_seen  = 1'b0;
  endfunction

  function automatic void span_wall();
    depth_now = 0;
    wall_pos  = {1'b0, pos_now};
  endfunction

  function automatic void span_note(input logic [16:0] from);
    logic [16:0] len;
    len = {1'b0, pos_now} - from;
    if (len > 17'h0FFFF) len = 17'h0FFFF;
    if (len[15:0] > best_span) best_span = len[15:0];
  endfunction

  // Advance the predictor by one token; returns 1 when the token yields a result.
  function automatic bit span_step(input tok_t t, output res_t r);
    int v;
    v = $signed(t.bracket_value);
    r = '0;
    if (pos_now == POS_LAST) begin
      ovf_seen = 1'b1;
      span_wall();
    end else begin
      if (v >= 0) begin
        if (depth_now >= STACK_DEPTH) begin
          ovf_seen = 1'b1;
          span_wall();
        end else begin
          open_kind[depth_now] = v;
          open_at[depth_now]   = pos_now;
          depth_now++;
        end
      end else if (depth_now > 0 && open_kind[depth_now-1] == -v) begin
        depth_now--;
        if (depth_now == 0) span_note(wall_pos);
        else span_note({1'b0, open_at[depth_now-1]});
      end else begin
        span_wall();
      end
      pos_now = pos_now + 16'd1;
    end
    if (t.last_item) begin
      r.longest_length = best_span;
      r.overflow       = ovf_seen;
      span_clear();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (tok_valid && tok_ready) begin
        tokens_in++;
        if (span_step(tok_req, predicted)) begin
          due.insert(due.size(), req_known ? req_want : predicted);
        end
      end
      if (res_valid && res_ready) begin
        res_seen++;
        if (res.overflow) ovf_results++;
        if (due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result len %0d ovf %0b", $time,
                   res.longest_length, res.overflow);
        end else begin
          want_now = due.pop_front();
          if (res.longest_length !== want_now.longest_length) begin
            errors++;
            $display("%0t: longest_length expected %0d, got %0d", $time,
                     want_now.longest_length, res.longest_length);
          end
          if (res.overflow !== want_now.overflow) begin
            errors++;
            $display("%0t: overflow expected %0b, got %0b", $time,
                     want_now.overflow, res.overflow);
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((tok_valid && tok_ready) || (res_valid && res_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("longest_balanced_bracket_span test failed");
        $finish;
      end
    end
  end

  // Result side: random back-pressure bursts, one long hold-off.
  initial begin : drain
    int gap;
    bit busy;
    bit held;
    gap  = 0;
    busy = 1'b1;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) busy = !busy;
      if (!held && res_seen >= STALL_AFTER) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_ready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        res_ready <= 1'b0;
      end else if (!calm && busy && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 7) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  task automatic offer(input logic signed [15:0] val, input logic fin,
                       input logic known, input res_t want);
    if (tx_idle_on && !calm && $urandom_range(0, 3) == 0) begin
      tok_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tok_valid <= 1'b1;
    tok_req   <= tok_t'{bracket_value: val, last_item: fin};
    req_known <= known;
    req_want  <= want;
    @(posedge clk);
    while (!tok_ready) @(posedge clk);
    if (fin) seq_sent++;
  endtask

  // Hold requests until every result is back, then let the pipeline empty.
  task automatic settle();
    tok_valid <= 1'b0;
    while (res_seen != seq_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed nesting with random types, plus noise and wrong closes.
  task automatic random_run(input int len, input int close_pct);
    int opened [$];
    int t;
    int k;
    logic signed [15:0] v;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 6) begin
        v = 16'($urandom());
        if (v < 0) opened.delete();
        else opened.insert(opened.size(), int'(v));
      end else if (opened.size() > 0 && $urandom_range(0, 99) < close_pct) begin
        if (opened[$] == 0) begin
          v = -16'($urandom_range(1, 3));
          opened.delete();
        end else begin
          v = 16'(-opened[$]);
          opened.delete(opened.size() - 1);
        end
      end else begin
        if ($urandom_range(0, 7) == 0) t = $urandom_range(0, 32767);
        else if ($urandom_range(0, 15) == 0) t = 0;
        else t = $urandom_range(1, 3);
        v = 16'(t);
        opened.insert(opened.size(), t);
      end
      offer(v, k == len - 1, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int n;
    int len;
    res_t w;
    span_clear();
    plan = '{
      '{16'sd0,      1'b1, 1'b1, 16'd0, 1'b0},
      '{-16'sd1,     1'b1, 1'b1, 16'd0, 1'b0},
      '{16'sd0,      1'b0, 1'b0, 16'd0, 1'b0},
      '{16'sd0,      1'b1, 1'b1, 16'd0, 1'b0},
      '{16'sd5,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd5,     1'b1, 1'b1, 16'd2, 1'b0},
      '{16'sd3,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd4,     1'b0, 1'b0, 16'd0, 1'b0},
      '{16'sd7,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd7,     1'b1, 1'b0, 16'd0, 1'b0},
      '{16'sd32767,  1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd32767, 1'b1, 1'b1, 16'd2, 1'b0},
      '{16'sh8000,   1'b1, 1'b1, 16'd0, 1'b0},
      '{16'sd32767,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'sh8000,   1'b1, 1'b1, 16'd0, 1'b0},
      '{16'sd1,      1'b0, 1'b0, 16'd0, 1'b0},
      '{16'sd2,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd2,     1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd1,     1'b1, 1'b0, 16'd0, 1'b0},
      '{16'sd1,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd1,     1'b0, 1'b0, 16'd0, 1'b0},
      '{16'sd2,      1'b0, 1'b0, 16'd0, 1'b0},
      '{-16'sd2,     1'b1, 1'b0, 16'd0, 1'b0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_on = 1'b1;
    foreach (plan[i]) begin
      w = '{longest_length: plan[i].len, overflow: plan[i].ovf};
      offer(plan[i].val, plan[i].fin, plan[i].known, w);
    end
    settle();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(30, 120);
        random_run(len, 40);
      end else begin
        len = $urandom_range(1, 16);
        random_run(len, 50);
      end
      n += len;
    end
    settle();

    calm = 1'b1;
    tx_idle_on = 1'b0;
    n = 0;
    while (n < CALM_ITEMS) begin
      len = $urandom_range(1, 16);
      random_run(len, 50);
      n += len;
    end

    tok_valid <= 1'b0;
    while (res_seen != seq_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due.size() != 0) begin
      errors += due.size();
      $display("%0t: %0d results never arrived", $time, due.size());
    end
    $display("Covered %0d tokens in %0d sequences, %0d results with overflow set,",
             tokens_in, seq_sent, ovf_results);
    $display("including edge tokens, wrong-type closes and a %0d-cycle result stall.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("longest_balanced_bracket_span test passed");
    end else begin
      $display("longest_balanced_bracket_span test failed");
    end
    $finish;
  end

endmodule
